### hdl/bqlp_pkg.sv
// ----------------------------------------------------------------------------
// bqlp_pkg
// shared constants, register map and helpers for the biquad lowpass core
// ----------------------------------------------------------------------------
package bqlp_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 18;

    localparam int NUM_COEFS       = 5;
    localparam int APB_DATA_BITS   = 32;
    localparam int ADDR_BITS       = 5;
    localparam int REG_IDX_BITS    = ADDR_BITS - 2;

    // register map, byte address = 4 * index
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_NOW       = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_PREV      = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_PREV2     = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_FEEDBACK_PREV  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_FEEDBACK_PREV2 = 3'd4;

    // 64-bit add that clamps at the signed limits
    function automatic logic signed [63:0] sat_add64(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [64:0] sum;
        logic signed [63:0] res;
        begin
            sum = {a[63], a} + {b[63], b};
            if (sum[64] != sum[63])
            begin
                res = sum[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
            end
            else
            begin
                res = sum[63:0];
            end
            return res;
        end
    endfunction

endpackage

### hdl/bqlp_if.sv
// ----------------------------------------------------------------------------
// bqlp_if
// valid/ready stream channels for samples in and filtered results out
// ----------------------------------------------------------------------------
interface bqlp_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bqlp_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          clipped;

    modport source (output valid, output filtered, output clipped, input ready);
    modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

### hdl/bqlp_regs.sv
// ----------------------------------------------------------------------------
// bqlp_regs
// apb coefficient register bank, five signed q2.(n-2) coefficients
// ----------------------------------------------------------------------------
module bqlp_regs
    import bqlp_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
)(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ADDR_BITS-1:0]                    paddr,
    input  logic [APB_DATA_BITS-1:0]                pwdata,
    output logic [APB_DATA_BITS-1:0]                prdata,
    output logic                                    pready,
    output logic [NUM_COEFS-1:0][COEF_BITS-1:0]     coefs
);

    localparam logic [COEF_BITS-1:0] UNITY = COEF_BITS'(1) << (COEF_BITS - 2);
    // gain_now sits in the lowest slot, everything else clears
    localparam logic [NUM_COEFS-1:0][COEF_BITS-1:0] COEF_RESET =
        {{((NUM_COEFS - 1) * COEF_BITS){1'b0}}, UNITY};

    logic [NUM_COEFS-1:0][COEF_BITS-1:0] coef_reg;
    logic [NUM_COEFS-1:0][COEF_BITS-1:0] coef_next;
    logic [REG_IDX_BITS-1:0]             idx;
    logic                                wr_en;
    logic [COEF_BITS-1:0]                rd_coef;

    assign idx    = paddr[ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign coefs  = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GAIN_NOW:       coef_next[REG_GAIN_NOW]       = pwdata[COEF_BITS-1:0];
                REG_GAIN_PREV:      coef_next[REG_GAIN_PREV]      = pwdata[COEF_BITS-1:0];
                REG_GAIN_PREV2:     coef_next[REG_GAIN_PREV2]     = pwdata[COEF_BITS-1:0];
                REG_FEEDBACK_PREV:  coef_next[REG_FEEDBACK_PREV]  = pwdata[COEF_BITS-1:0];
                REG_FEEDBACK_PREV2: coef_next[REG_FEEDBACK_PREV2] = pwdata[COEF_BITS-1:0];
                default:            coef_next = coef_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GAIN_NOW:       rd_coef = coef_reg[REG_GAIN_NOW];
            REG_GAIN_PREV:      rd_coef = coef_reg[REG_GAIN_PREV];
            REG_GAIN_PREV2:     rd_coef = coef_reg[REG_GAIN_PREV2];
            REG_FEEDBACK_PREV:  rd_coef = coef_reg[REG_FEEDBACK_PREV];
            REG_FEEDBACK_PREV2: rd_coef = coef_reg[REG_FEEDBACK_PREV2];
            default:            rd_coef = '0;
        endcase
    end

    // read back sign extended
    assign prdata = APB_DATA_BITS'($signed(rd_coef));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

### hdl/bqlp_section.sv
// ----------------------------------------------------------------------------
// bqlp_section
// direct form i section: history registers, five products, round, saturate
// ----------------------------------------------------------------------------
module bqlp_section
    import bqlp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
)(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [NUM_COEFS-1:0][COEF_BITS-1:0] coefs,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic                                advance,
    output logic signed [SAMPLE_BITS-1:0]       y,
    output logic                                clip
);

    localparam int FRAC_BITS = COEF_BITS - 2;
    localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
    localparam int FULL_W    = PROD_W + 3;
    localparam int ACC_W     = (FULL_W > 64) ? 64 : FULL_W;
    localparam int YW        = ACC_W - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [YW-1:0]    Y_TOP =
        {{(YW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [YW-1:0]    Y_BOT =
        {{(YW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] in_prev_reg;
    logic signed [SAMPLE_BITS-1:0] in_prev2_reg;
    logic signed [SAMPLE_BITS-1:0] out_prev_reg;
    logic signed [SAMPLE_BITS-1:0] out_prev2_reg;

    logic signed [COEF_BITS-1:0] c_now;
    logic signed [COEF_BITS-1:0] c_prev;
    logic signed [COEF_BITS-1:0] c_prev2;
    logic signed [COEF_BITS-1:0] c_fb_prev;
    logic signed [COEF_BITS-1:0] c_fb_prev2;

    logic signed [PROD_W-1:0] p_now;
    logic signed [PROD_W-1:0] p_prev;
    logic signed [PROD_W-1:0] p_prev2;
    logic signed [PROD_W-1:0] p_fb_prev;
    logic signed [PROD_W-1:0] p_fb_prev2;

    logic signed [ACC_W-1:0] acc_r;
    logic signed [YW-1:0]    y_full;

    assign c_now      = $signed(coefs[REG_GAIN_NOW]);
    assign c_prev     = $signed(coefs[REG_GAIN_PREV]);
    assign c_prev2    = $signed(coefs[REG_GAIN_PREV2]);
    assign c_fb_prev  = $signed(coefs[REG_FEEDBACK_PREV]);
    assign c_fb_prev2 = $signed(coefs[REG_FEEDBACK_PREV2]);

    // five products in parallel
    assign p_now      = c_now      * sample;
    assign p_prev     = c_prev     * in_prev_reg;
    assign p_prev2    = c_prev2    * in_prev2_reg;
    assign p_fb_prev  = c_fb_prev  * out_prev_reg;
    assign p_fb_prev2 = c_fb_prev2 * out_prev2_reg;

    generate
        if (FULL_W > 64)
        begin : g_sat_chain
            // widest settings: partial sums clamp at the 64-bit limits
            logic signed [63:0] s1;
            logic signed [63:0] s2;
            logic signed [63:0] s3;
            logic signed [63:0] s4;
            logic signed [63:0] s5;

            assign s1    = 64'(p_now);
            assign s2    = sat_add64(s1, 64'(p_prev));
            assign s3    = sat_add64(s2, 64'(p_prev2));
            assign s4    = sat_add64(s3, -64'(p_fb_prev));
            assign s5    = sat_add64(s4, -64'(p_fb_prev2));
            assign acc_r = ACC_W'(sat_add64(s5, 64'(HALF)));
        end
        else
        begin : g_plain_sum
            // accumulator is wide enough that nothing can overflow
            assign acc_r = ACC_W'(p_now) + ACC_W'(p_prev) + ACC_W'(p_prev2)
                         - ACC_W'(p_fb_prev) - ACC_W'(p_fb_prev2) + HALF;
        end
    endgenerate

    // floor shift, round half up
    assign y_full = YW'(acc_r >>> FRAC_BITS);

    always_comb
    begin
        if (y_full > Y_TOP)
        begin
            y    = Y_TOP[SAMPLE_BITS-1:0];
            clip = 1'b1;
        end
        else if (y_full < Y_BOT)
        begin
            y    = Y_BOT[SAMPLE_BITS-1:0];
            clip = 1'b1;
        end
        else
        begin
            y    = y_full[SAMPLE_BITS-1:0];
            clip = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_prev_reg   <= '0;
            in_prev2_reg  <= '0;
            out_prev_reg  <= '0;
            out_prev2_reg <= '0;
        end
        else if (advance)
        begin
            in_prev2_reg  <= in_prev_reg;
            in_prev_reg   <= sample;
            out_prev2_reg <= out_prev_reg;
            out_prev_reg  <= y;
        end
    end

    a_in_hist : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> in_prev_reg == $past(sample) && in_prev2_reg == $past(in_prev_reg))
        else $error("input history not shifted on advance");

    a_out_hist : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_prev_reg == $past(y) && out_prev2_reg == $past(out_prev_reg))
        else $error("output history does not hold the saturated result");

    a_hist_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(in_prev_reg) && $stable(out_prev_reg))
        else $error("history changed without an advancing sample");

endmodule

### hdl/biquad_lowpass_filter_core.sv
// ----------------------------------------------------------------------------
// biquad_lowpass_filter_core
// second-order iir biquad, direct form i, fixed point, apb coefficients
// ----------------------------------------------------------------------------
// each sample beat produces exactly one result beat, and a new sample can be
// taken every cycle unless the result side stalls: the sample lands in an
// input register, the five multiplies, the adder tree, rounding and
// saturation run combinationally into the result register, and the history
// (two inputs, two saturated outputs) updates with it for the next sample.
// coefficients are signed q2.(COEF_BITS-2) at byte addresses 0x00 gain_now,
// 0x04 gain_prev, 0x08 gain_prev2, 0x0c feedback_prev, 0x10 feedback_prev2;
// the two feedback terms are subtracted. reset gives a unity pass-through
// with cleared history. write coefficients only while the core is idle.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter_core
    import bqlp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
)(
    input  logic                     clk,
    input  logic                     rst_n,
    // apb coefficient port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    // streams
    bqlp_in_if.sink                  samples,
    bqlp_out_if.source               results
);

    localparam logic [SAMPLE_BITS-1:0] SAT_TOP = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_BOT = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic [NUM_COEFS-1:0][COEF_BITS-1:0] coefs;

    // input stage
    logic                          a_valid_reg;
    logic                          a_valid_next;
    logic signed [SAMPLE_BITS-1:0] a_sample_reg;

    // result stage
    logic                          b_valid_reg;
    logic                          b_valid_next;
    logic signed [SAMPLE_BITS-1:0] filtered_reg;
    logic                          clipped_reg;

    logic                          b_free;
    logic                          a_advance;
    logic                          in_beat;
    logic signed [SAMPLE_BITS-1:0] sec_y;
    logic                          sec_clip;

    bqlp_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    bqlp_section #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_section (
        .clk     (clk),
        .rst_n   (rst_n),
        .coefs   (coefs),
        .sample  (a_sample_reg),
        .advance (a_advance),
        .y       (sec_y),
        .clip    (sec_clip)
    );

    // the result register frees up when empty or when its beat is taken
    assign b_free    = !b_valid_reg || results.ready;
    // the held sample is filtered and moves on when the result slot is free
    assign a_advance = a_valid_reg && b_free;
    // take a new sample whenever the input register empties this cycle
    assign samples.ready = !a_valid_reg || a_advance;
    assign in_beat       = samples.valid && samples.ready;

    assign results.valid    = b_valid_reg;
    assign results.filtered = filtered_reg;
    assign results.clipped  = clipped_reg;

    always_comb
    begin
        if (in_beat)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_advance)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end

        if (a_advance)
        begin
            b_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            a_sample_reg <= samples.sample;
        end
        if (a_advance)
        begin
            filtered_reg <= sec_y;
            clipped_reg  <= sec_clip;
        end
    end

    a_result_load : assert property (@(posedge clk) disable iff (!rst_n)
        a_advance |=> results.valid && results.filtered == $past(sec_y)
                      && results.clipped == $past(sec_clip))
        else $error("filtered sample did not reach the result register");

    a_clip_rail : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.clipped |->
            results.filtered == SAT_TOP || results.filtered == SAT_BOT)
        else $error("clipped result not at a saturation rail");

    a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> samples.ready)
        else $error("input stage empty but not ready");

endmodule

### sim/bqlp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bqlp_checker
// watches the coefficient port and both streams, predicts every filtered
// beat from its own copy of the coefficients and history, and compares
// ----------------------------------------------------------------------------
module bqlp_checker
    import bqlp_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    // coefficient port, observed only
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ADDR_BITS-1:0]              paddr,
    input  logic [APB_DATA_BITS-1:0]          pwdata,
    input  logic [APB_DATA_BITS-1:0]          prdata,
    input  logic                              pready,
    // sample stream
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic signed [SAMPLE_BITS_DEF-1:0] in_sample,
    // result stream
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [SAMPLE_BITS_DEF-1:0] out_filtered,
    input  logic                              out_clipped,
    // to the testbench top
    output int                                mismatches,
    output int                                outstanding
);

    localparam int SB   = SAMPLE_BITS_DEF;
    localparam int CB   = COEF_BITS_DEF;
    localparam int FRAC = CB - 2;

    localparam longint OUT_MAX    = (longint'(1) << (SB - 1)) - 1;
    localparam longint OUT_MIN    = -(longint'(1) << (SB - 1));
    localparam longint ROUND_HALF = longint'(1) << (FRAC - 1);

    typedef struct packed {
        logic signed [SB-1:0] filtered;
        logic                 clipped;
    } filt_beat_t;

    logic signed [CB-1:0] coef [NUM_COEFS];
    logic signed [SB-1:0] in_prev, in_prev2, out_prev, out_prev2;
    logic [REG_IDX_BITS-1:0] reg_idx;
    filt_beat_t predicted_outputs[$];
    filt_beat_t predicted;
    filt_beat_t oldest;

    // direct form i with round half up and saturation; the sum needs at most
    // 37 bits at these widths, so a 64-bit accumulator never clamps
    function automatic filt_beat_t biquad_response(input logic signed [SB-1:0] x);
        longint     acc;
        longint     y;
        filt_beat_t beat;
        acc = longint'(coef[REG_GAIN_NOW])       * longint'(x)
            + longint'(coef[REG_GAIN_PREV])      * longint'(in_prev)
            + longint'(coef[REG_GAIN_PREV2])     * longint'(in_prev2)
            - longint'(coef[REG_FEEDBACK_PREV])  * longint'(out_prev)
            - longint'(coef[REG_FEEDBACK_PREV2]) * longint'(out_prev2);
        y = (acc + ROUND_HALF) >>> FRAC;
        beat.clipped = 1'b1;
        if (y > OUT_MAX)
        begin
            y = OUT_MAX;
        end
        else if (y < OUT_MIN)
        begin
            y = OUT_MIN;
        end
        else
        begin
            beat.clipped = 1'b0;
        end
        beat.filtered = y[SB-1:0];
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef[REG_GAIN_NOW]       = CB'(1) << FRAC;
            coef[REG_GAIN_PREV]      = '0;
            coef[REG_GAIN_PREV2]     = '0;
            coef[REG_FEEDBACK_PREV]  = '0;
            coef[REG_FEEDBACK_PREV2] = '0;
            in_prev   = '0;
            in_prev2  = '0;
            out_prev  = '0;
            out_prev2 = '0;
            predicted_outputs.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            reg_idx = paddr[ADDR_BITS-1:2];
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    // upper data bits and unused indexes are ignored
                    if (reg_idx < NUM_COEFS)
                        coef[reg_idx] = pwdata[CB-1:0];
                end
                else if (reg_idx < NUM_COEFS && prdata[CB-1:0] !== coef[reg_idx])
                begin
                    $error("prdata[%0d] expected %0d actual %0d", reg_idx,
                           coef[reg_idx], $signed(prdata[CB-1:0]));
                    mismatches = mismatches + 1;
                end
            end

            if (in_valid && in_ready)
            begin
                predicted = biquad_response(in_sample);
                predicted_outputs.push_back(predicted);
                in_prev2  = in_prev;
                in_prev   = in_sample;
                out_prev2 = out_prev;
                out_prev  = predicted.filtered;
            end

            if (out_valid && out_ready)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    $error("result beat with no sample pending: filtered %0d clipped %0b",
                           out_filtered, out_clipped);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    oldest = predicted_outputs.pop_front();
                    if (out_filtered !== oldest.filtered)
                    begin
                        $error("filtered expected %0d actual %0d",
                               oldest.filtered, out_filtered);
                        mismatches = mismatches + 1;
                    end
                    if (out_clipped !== oldest.clipped)
                    begin
                        $error("clipped expected %0b actual %0b",
                               oldest.clipped, out_clipped);
                        mismatches = mismatches + 1;
                    end
                end
            end
            outstanding <= predicted_outputs.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the biquad lowpass core: apb coefficient loads,
// directed corner samples, then randomized phases under varied flow control
// ----------------------------------------------------------------------------
module tb_top;
    import bqlp_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int CB = COEF_BITS_DEF;

    // coefficient corners in q2.16
    localparam logic signed [CB-1:0] COEF_MAX   = 18'sh1FFFF;
    localparam logic signed [CB-1:0] COEF_MIN   = 18'sh20000;
    localparam logic signed [CB-1:0] COEF_UNITY = 18'sh10000;
    localparam logic signed [CB-1:0] COEF_HALF  = 18'sh08000;
    localparam logic signed [CB-1:0] COEF_ZERO  = 18'sh00000;

    // butterworth lowpass near fs/10, coefficients precomputed
    localparam logic signed [CB-1:0] LP_B0 = 18'sd4426;
    localparam logic signed [CB-1:0] LP_B1 = 18'sd8852;
    localparam logic signed [CB-1:0] LP_A1 = -18'sd74908;
    localparam logic signed [CB-1:0] LP_A2 = 18'sd27054;

    localparam logic signed [SB-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SB-1:0] SAMPLE_MIN = 16'sh8000;

    // indexes past the register map, writes there must be dropped
    localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_HI = 3'd7;

    // flow control profiles
    typedef enum int { FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH } flow_mode_t;
    // coefficient sets for the random phases
    typedef enum int { SET_LOWPASS, SET_WILD, SET_CORNERS, SET_GENTLE } coef_set_t;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int FLOOD_ITEMS     = 40;

    logic clk;
    logic rst_n;

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_BITS-1:0]     paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    bqlp_in_if  #(.SAMPLE_BITS(SB)) samples_ch ();
    bqlp_out_if #(.SAMPLE_BITS(SB)) results_ch ();

    // flow control knobs, percent of cycles
    int src_idle_pct;
    int sink_stall_pct;
    // running count of requests for a long output hold-off
    int hold_reqs;

    int mismatches;
    int outstanding;

    biquad_lowpass_filter_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples_ch),
        .results (results_ch)
    );

    bqlp_checker filter_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (samples_ch.valid),
        .in_ready     (samples_ch.ready),
        .in_sample    (samples_ch.sample),
        .out_valid    (results_ch.valid),
        .out_ready    (results_ch.ready),
        .out_filtered (results_ch.filtered),
        .out_clipped  (results_ch.clipped),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side: random stalls, plus a long hold-off on request so the
    // core fills up and pushes back on the sample stream
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        results_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_left = 80;
                hold_seen = hold_reqs;
            end
            if (hold_left > 0)
            begin
                results_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                results_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // hard stop in case the core hangs
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // one apb transfer: setup phase, access phase, then an idle gap with psel low
    // so a following transfer never re-drives psel in the same step
    task automatic apb_xfer(input bit is_write, input logic [REG_IDX_BITS-1:0] idx,
                            input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // coefficient write with junk in the unused upper data bits
    task automatic write_coef(input logic [REG_IDX_BITS-1:0] idx,
                              input logic signed [CB-1:0] value);
        logic [APB_DATA_BITS-1:0] junk;
        junk = $urandom;
        apb_xfer(1'b1, idx, {junk[APB_DATA_BITS-1:CB], value});
    endtask

    // load all five coefficients and read each back
    task automatic load_coefs(input logic signed [CB-1:0] b0, b1, b2, a1, a2);
        write_coef(REG_GAIN_NOW, b0);
        write_coef(REG_GAIN_PREV, b1);
        write_coef(REG_GAIN_PREV2, b2);
        write_coef(REG_FEEDBACK_PREV, a1);
        write_coef(REG_FEEDBACK_PREV2, a2);
        apb_xfer(1'b0, REG_GAIN_NOW, '0);
        apb_xfer(1'b0, REG_GAIN_PREV, '0);
        apb_xfer(1'b0, REG_GAIN_PREV2, '0);
        apb_xfer(1'b0, REG_FEEDBACK_PREV, '0);
        apb_xfer(1'b0, REG_FEEDBACK_PREV2, '0);
    endtask

    // offer one sample beat and hold it until taken; on an idle gap valid
    // drops and the data bus carries noise
    task automatic push_sample(input logic signed [SB-1:0] x);
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= x;
        @(posedge clk);
        while (!samples_ch.ready) @(posedge clk);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            samples_ch.valid  <= 1'b0;
            samples_ch.sample <= SB'($urandom);
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    // drop valid, wait for every predicted beat to come back, then let the
    // pipeline settle before touching coefficients
    task automatic drain_results();
        samples_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly full-scale noise, with rails and small values mixed in
    function automatic logic signed [SB-1:0] random_sample();
        logic signed [SB-1:0] s;
        case ($urandom_range(7))
            0: s = SAMPLE_MAX;
            1: s = SAMPLE_MIN;
            2:
            begin
                s = SB'($urandom_range(255));
                if ($urandom_range(1))
                    s = -s;
            end
            default: s = SB'($urandom);
        endcase
        return s;
    endfunction

    function automatic logic signed [CB-1:0] pick_coef(input coef_set_t kind);
        logic signed [CB-1:0] c;
        case (kind)
            SET_CORNERS: c = $urandom_range(1) ? COEF_MAX : COEF_MIN;
            SET_GENTLE:  c = CB'(int'($urandom_range(65535)) - 32768);
            default:     c = CB'($urandom);
        endcase
        return c;
    endfunction

    task automatic set_flow(input flow_mode_t mode);
        case (mode)
            FLOW_FREE:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            FLOW_SRC_IDLE:
            begin
                src_idle_pct   = 86;
                sink_stall_pct = 0;
            end
            FLOW_SINK_STALL:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 86;
            end
            default:
            begin
                src_idle_pct   = 12;
                sink_stall_pct = 12;
            end
        endcase
    endtask

    initial
    begin
        coef_set_t  kind;
        flow_mode_t mode;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;
        hold_reqs         = 0;
        set_flow(FLOW_FREE);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset coefficients give a straight pass-through
        push_sample(16'sd0);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sh5555);
        push_sample(16'shAAAA);
        drain_results();

        // writes past the register map must not land anywhere
        write_coef(REG_UNUSED_LO, COEF_MAX);
        write_coef(REG_UNUSED_HI, COEF_MIN);
        push_sample(16'sd1234);
        drain_results();

        // largest positive gain: clip at both rails
        load_coefs(COEF_MAX, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(16'sd100);
        drain_results();

        // most negative gain flips the rails
        load_coefs(COEF_MIN, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        drain_results();

        // half gain lands odd inputs exactly on the rounding midpoint
        load_coefs(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sd3);
        push_sample(-16'sd3);
        drain_results();

        // runaway feedback: saturated outputs must be what goes into history
        load_coefs(COEF_UNITY, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
        repeat (6) push_sample(16'sd1000);
        drain_results();

        // random phases, each pairing a coefficient set with a flow profile
        for (int ph = 0; ph < PHASES; ph++)
        begin
            mode = flow_mode_t'(ph % 4);
            kind = coef_set_t'((ph * 3) % 4);
            if (kind == SET_LOWPASS)
                load_coefs(LP_B0, LP_B1, LP_B0, LP_A1, LP_A2);
            else
                load_coefs(pick_coef(kind), pick_coef(kind), pick_coef(kind),
                           pick_coef(kind), pick_coef(kind));
            set_flow(mode);
            repeat (ITEMS_PER_PHASE) push_sample(random_sample());
            drain_results();
        end

        // back-pressure: sender floods while the result side holds off
        set_flow(FLOW_FREE);
        load_coefs(LP_B0, LP_B1, LP_B0, LP_A1, LP_A2);
        hold_reqs++;
        repeat (FLOOD_ITEMS) push_sample(random_sample());
        drain_results();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### biquad_lowpass_filter_core.f
hdl/bqlp_pkg.sv
hdl/bqlp_if.sv
hdl/bqlp_regs.sv
hdl/bqlp_section.sv
hdl/biquad_lowpass_filter_core.sv
sim/bqlp_checker.sv
sim/tb_top.sv
